### src/image_error_statistics_assert.svh
// Assertion macros for the image error statistics RTL.
// Both expect clk_i in the scope where they are used; IES_ASSERT also expects rst_ni.
`ifndef IMAGE_ERROR_STATISTICS_ASSERT_SVH
`define IMAGE_ERROR_STATISTICS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IES_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("image_error_statistics: assertion failed");

// Check a property on every clock edge, reset included.
`define IES_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("image_error_statistics: assertion failed");

`endif

### src/ies_pkg.sv
`default_nettype none
package ies_pkg;

  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxPixels = 4194304;
  localparam int DefFracBits  = 16;

  localparam int PixW     = 8;
  localparam int FwW      = 13;
  localparam int WinW     = 12;
  localparam int RowW     = 12;
  localparam int ResW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH,
    REG_WIN_X0,
    REG_WIN_Y0,
    REG_WIN_X1,
    REG_WIN_Y1
  } cfg_reg_e;

  // Finalisation operations, run in this order
  typedef enum logic [2:0] {
    OP_N_RSQ,
    OP_RSUM_SQ,
    OP_N_DSQ,
    OP_DMAG_SQ,
    OP_N_N,
    OP_DIV_MSE,
    OP_DIV_VR,
    OP_DIV_VN
  } op_e;

  typedef struct packed {
    logic take;
    logic start;
    logic step;
    logic commit;
    logic clear;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
  } stat_t;

endpackage
`default_nettype wire

### src/ies_dp.sv
`default_nettype none
module ies_dp #(
  parameter int MaxWidth  = ies_pkg::DefMaxWidth,
  parameter int MaxPixels = ies_pkg::DefMaxPixels,
  parameter int FracBits  = ies_pkg::DefFracBits
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ies_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [ies_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic [ies_pkg::PixW-1:0]            ref_pixel_i,
  input  wire logic [ies_pkg::PixW-1:0]            test_pixel_i,
  input  wire ies_pkg::cmd_t                       cmd_i,
  output ies_pkg::stat_t                           stat_o,
  output logic [ies_pkg::ResW-1:0]                 mse_o,
  output logic [ies_pkg::ResW-1:0]                 var_ref_o,
  output logic [ies_pkg::ResW-1:0]                 var_noise_o,
  output logic [$clog2(MaxPixels+1)-1:0]           pixel_count_o,
  output logic                                     zero_noise_o,
  output logic                                     count_overflow_o
);
  import ies_pkg::*;

  localparam int CntW  = $clog2(MaxPixels + 1);
  localparam int ColW  = $clog2(MaxWidth);
  localparam int WW    = (ColW + 1 > FwW) ? ColW + 1 : FwW;
  localparam int RSumW = CntW + 8;
  localparam int SqW   = CntW + 16;
  localparam int DSumW = CntW + 9;
  localparam int MW    = CntW + 8;
  localparam int PW    = 2 * CntW + 16;
  localparam int DW    = 2 * CntW;
  localparam int XW    = PW + FracBits;
  localparam int HiW   = XW - DivSteps;

  // configuration
  logic [FwW-1:0]  fw_q;
  logic [WinW-1:0] x0_q, y0_q, x1_q, y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FwW'(4096);
      x0_q <= '0;
      y0_q <= '0;
      x1_q <= '1;
      y1_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH: fw_q <= cfg_data_i[FwW-1:0];
        REG_WIN_X0:      x0_q <= cfg_data_i[WinW-1:0];
        REG_WIN_Y0:      y0_q <= cfg_data_i[WinW-1:0];
        REG_WIN_X1:      x1_q <= cfg_data_i[WinW-1:0];
        REG_WIN_Y1:      y1_q <= cfg_data_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // position and accumulators
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [CntW-1:0]  cnt_q;
  logic [RSumW-1:0] rsum_q;
  logic [SqW-1:0]   rsq_q, dsq_q;
  logic [DSumW-1:0] dsum_q;
  logic             ovf_q;

  logic [WW-1:0]    col_ext, fw_ext, w_eff;
  logic             in_win, wrap;
  logic [8:0]       d9;
  logic [PixW-1:0]  dmag8;
  logic [15:0]      rr, dd;

  always_comb begin
    col_ext = WW'(col_q);
    fw_ext  = WW'(fw_q);
    w_eff   = (fw_q == '0 || fw_ext > WW'(MaxWidth)) ? WW'(MaxWidth) : fw_ext;
    wrap    = (col_ext + WW'(1)) >= w_eff;
    in_win  = (col_ext >= WW'(x0_q)) && (col_ext <= WW'(x1_q)) &&
              (row_q >= y0_q) && (row_q <= y1_q);
    d9      = {1'b0, test_pixel_i} - {1'b0, ref_pixel_i};
    dmag8   = d9[8] ? 8'(-d9) : d9[7:0];
    rr      = 16'(ref_pixel_i) * 16'(ref_pixel_i);
    dd      = 16'(dmag8) * 16'(dmag8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      rsum_q <= '0;
      rsq_q  <= '0;
      dsq_q  <= '0;
      dsum_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      rsum_q <= '0;
      rsq_q  <= '0;
      dsq_q  <= '0;
      dsum_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.take) begin
      if (in_win) begin
        if (cnt_q >= CntW'(MaxPixels)) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q  <= cnt_q + CntW'(1);
          rsum_q <= rsum_q + RSumW'(ref_pixel_i);
          rsq_q  <= rsq_q + SqW'(rr);
          dsq_q  <= dsq_q + SqW'(dd);
          dsum_q <= dsum_q + {{(DSumW-9){d9[8]}}, d9};
        end
      end
      if (wrap) begin
        col_q <= '0;
        row_q <= row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // shift-add multiplier and restoring divider
  logic [MW-1:0]       dmag;
  logic [PW-1:0]       ma_q, prod_q, t_q, nr_q, nn_q;
  logic [MW-1:0]       mb_q;
  logic [DW-1:0]       den2_q, den;
  logic [DW-1:0]       rem_q;
  logic [DivSteps-1:0] xlo_q, q_q;
  logic                sat_q;
  logic [ResW-1:0]     mse_q, vr_q, vn_q;
  logic                is_mul;
  logic [PW-1:0]       num;
  logic [XW-1:0]       xnum;
  logic [HiW-1:0]      hi;
  logic [DW:0]         r2;
  logic [ResW-1:0]     qres;

  always_comb begin
    dmag   = dsum_q[DSumW-1] ? MW'(-dsum_q) : MW'(dsum_q);
    is_mul = (cmd_i.op == OP_N_RSQ) || (cmd_i.op == OP_RSUM_SQ) ||
             (cmd_i.op == OP_N_DSQ) || (cmd_i.op == OP_DMAG_SQ) ||
             (cmd_i.op == OP_N_N);
    case (cmd_i.op)
      OP_DIV_VR: num = nr_q;
      OP_DIV_VN: num = nn_q;
      default:   num = PW'(dsq_q);
    endcase
    den  = (cmd_i.op == OP_DIV_MSE) ? DW'(cnt_q) : den2_q;
    xnum = {num, {FracBits{1'b0}}};
    hi   = xnum[XW-1:DivSteps];
    r2   = {rem_q, xlo_q[DivSteps-1]};
    qres = sat_q ? '1 : q_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (is_mul) begin
        prod_q <= '0;
        case (cmd_i.op)
          OP_N_RSQ:   begin ma_q <= PW'(rsq_q);  mb_q <= MW'(cnt_q); end
          OP_RSUM_SQ: begin ma_q <= PW'(rsum_q); mb_q <= MW'(rsum_q); end
          OP_N_DSQ:   begin ma_q <= PW'(dsq_q);  mb_q <= MW'(cnt_q); end
          OP_DMAG_SQ: begin ma_q <= PW'(dmag);   mb_q <= dmag; end
          default:    begin ma_q <= PW'(cnt_q);  mb_q <= MW'(cnt_q); end
        endcase
      end else begin
        sat_q <= XW'(hi) >= XW'(den);
        rem_q <= DW'(hi);
        xlo_q <= xnum[DivSteps-1:0];
        q_q   <= '0;
      end
    end else if (cmd_i.step) begin
      if (is_mul) begin
        if (mb_q[0]) prod_q <= prod_q + ma_q;
        ma_q <= ma_q << 1;
        mb_q <= mb_q >> 1;
      end else begin
        if (r2 >= {1'b0, den}) begin
          rem_q <= DW'(r2 - {1'b0, den});
          q_q   <= {q_q[DivSteps-2:0], 1'b1};
        end else begin
          rem_q <= r2[DW-1:0];
          q_q   <= {q_q[DivSteps-2:0], 1'b0};
        end
        xlo_q <= xlo_q << 1;
      end
    end else if (cmd_i.commit) begin
      case (cmd_i.op)
        OP_N_RSQ:   t_q    <= prod_q;
        OP_RSUM_SQ: nr_q   <= t_q - prod_q;
        OP_N_DSQ:   t_q    <= prod_q;
        OP_DMAG_SQ: nn_q   <= t_q - prod_q;
        OP_N_N:     den2_q <= prod_q[DW-1:0];
        OP_DIV_MSE: mse_q  <= qres;
        OP_DIV_VR:  vr_q   <= qres;
        OP_DIV_VN:  vn_q   <= qres;
        default: ;
      endcase
    end
  end

  // an empty window gives all-zero values
  always_comb begin
    stat_o.n_zero    = (cnt_q == '0);
    mse_o            = stat_o.n_zero ? '0 : mse_q;
    var_ref_o        = stat_o.n_zero ? '0 : vr_q;
    var_noise_o      = stat_o.n_zero ? '0 : vn_q;
    zero_noise_o     = !stat_o.n_zero && (nn_q == '0);
    pixel_count_o    = cnt_q;
    count_overflow_o = ovf_q;
  end

endmodule
`default_nettype wire

### src/ies_ctrl.sv
`default_nettype none
`include "image_error_statistics_assert.svh"
module ies_ctrl #(
  parameter int MulSteps = $clog2(ies_pkg::DefMaxPixels + 1) + 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_last_i,
  input  wire logic           out_stall_i,
  input  wire ies_pkg::stat_t stat_i,
  output ies_pkg::cmd_t       cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);
  import ies_pkg::*;

  localparam int MaxSteps = (MulSteps > DivSteps) ? MulSteps : DivSteps;
  localparam int StepW    = $clog2(MaxSteps);

  typedef enum logic [2:0] {S_RUN, S_START, S_STEP, S_COMMIT, S_OUT} state_e;

  state_e           state_q;
  op_e              op_q;
  logic [StepW-1:0] cnt_q;
  logic [StepW-1:0] last_step;
  logic             is_mul;

  always_comb begin
    is_mul    = (op_q == OP_N_RSQ) || (op_q == OP_RSUM_SQ) || (op_q == OP_N_DSQ) ||
                (op_q == OP_DMAG_SQ) || (op_q == OP_N_N);
    last_step = is_mul ? StepW'(MulSteps - 1) : StepW'(DivSteps - 1);
    in_stall_o  = (state_q != S_RUN);
    out_valid_o = (state_q == S_OUT);
    cmd_o        = '0;
    cmd_o.op     = op_q;
    cmd_o.take   = (state_q == S_RUN) && in_valid_i;
    cmd_o.start  = (state_q == S_START) && !stat_i.n_zero;
    cmd_o.step   = (state_q == S_STEP);
    cmd_o.commit = (state_q == S_COMMIT);
    cmd_o.clear  = (state_q == S_OUT) && !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      op_q    <= OP_N_RSQ;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_RUN: begin
          if (in_valid_i && in_last_i) begin
            state_q <= S_START;
            op_q    <= OP_N_RSQ;
          end
        end
        S_START: begin
          cnt_q   <= '0;
          state_q <= stat_i.n_zero ? S_OUT : S_STEP;
        end
        S_STEP: begin
          if (cnt_q == last_step) state_q <= S_COMMIT;
          else cnt_q <= cnt_q + StepW'(1);
        end
        S_COMMIT: begin
          if (op_q == OP_DIV_VN) begin
            state_q <= S_OUT;
          end else begin
            op_q    <= op_e'(op_q + 3'd1);
            state_q <= S_START;
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_RUN;
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

  `IES_ASSERT_ALWAYS(a_no_overlap, !(out_valid_o && !in_stall_o))
  `IES_ASSERT(a_last_starts, (in_valid_i && !in_stall_o && in_last_i) |=> (state_q == S_START))
  `IES_ASSERT(a_commit_after_step, cmd_o.commit |-> $past(state_q == S_STEP))
  `IES_ASSERT(a_clear_ends_result, cmd_o.clear |=> !out_valid_o)

endmodule
`default_nettype wire

### src/image_error_statistics.sv
// Image error statistics over a window of a raster pixel stream.
// Input channel: ref_pixel_i, test_pixel_i and last_pixel_i move on a transfer
// (in_valid_i high, in_stall_o low). While a frame streams in, one pixel
// pair is taken every cycle; the column and row follow frame_width.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (frame width, window x0, y0, x1, y1); write only when idle.
// On the pixel flagged last the block stalls input and finalises: five
// shift-add products (one multiplier bit a cycle, count width + 8 bits)
// and three restoring divisions (32 quotient bits), each with a load and
// a commit step. An empty window skips the products and divisions.
// Output channel: mse_o, var_ref_o, var_noise_o (16.16 by default),
// pixel_count_o, zero_noise_o and count_overflow_o move on a transfer
// (out_valid_o high, out_stall_i low). They hold while out_stall_i is high;
// the transfer clears the accumulators and the next frame may start.
// Reset clears position, accumulators and loads the default window.
`default_nettype none
module image_error_statistics #(
  parameter int MaxWidth  = ies_pkg::DefMaxWidth,
  parameter int MaxPixels = ies_pkg::DefMaxPixels,
  parameter int FracBits  = ies_pkg::DefFracBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ies_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ies_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ies_pkg::PixW-1:0]     ref_pixel_i,
  input  wire logic [ies_pkg::PixW-1:0]     test_pixel_i,
  input  wire logic                         last_pixel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ies_pkg::ResW-1:0]          mse_o,
  output logic [ies_pkg::ResW-1:0]          var_ref_o,
  output logic [ies_pkg::ResW-1:0]          var_noise_o,
  output logic [$clog2(MaxPixels+1)-1:0]    pixel_count_o,
  output logic                              zero_noise_o,
  output logic                              count_overflow_o
);
  import ies_pkg::*;

  // multiplier operand width: count width plus eight bits for pixel sums
  localparam int MulSteps = $clog2(MaxPixels + 1) + 8;

  cmd_t  cmd;
  stat_t stat;

  // sequence the finalisation and both handshakes
  ies_ctrl #(
    .MulSteps(MulSteps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_pixel_i),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  // accumulate, multiply, divide and hold the result
  ies_dp #(
    .MaxWidth (MaxWidth),
    .MaxPixels(MaxPixels),
    .FracBits (FracBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .ref_pixel_i     (ref_pixel_i),
    .test_pixel_i    (test_pixel_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mse_o           (mse_o),
    .var_ref_o       (var_ref_o),
    .var_noise_o     (var_noise_o),
    .pixel_count_o   (pixel_count_o),
    .zero_noise_o    (zero_noise_o),
    .count_overflow_o(count_overflow_o)
  );

endmodule
`default_nettype wire

### test/image_error_statistics_tb.sv
`timescale 1ns / 1ps
// Testbench for image_error_statistics: drives raster frames of pixel pairs,
// predicts the per-frame error statistics and checks every result transfer.
module image_error_statistics_tb;
  import ies_pkg::*;

  localparam int MaxPixels = 4194304;
  localparam int MaxWidth  = 4096;
  localparam int FracBits  = 16;
  localparam int CntW      = $clog2(MaxPixels + 1);
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 300;

  typedef struct {
    logic [31:0]     mse;
    logic [31:0]     var_ref;
    logic [31:0]     var_noise;
    logic [CntW-1:0] pixel_count;
    logic            zero_noise;
    logic            count_overflow;
  } frame_stats_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     ref_pixel_i = '0;
  logic [PixW-1:0]     test_pixel_i = '0;
  logic                last_pixel_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ResW-1:0]     mse_o, var_ref_o, var_noise_o;
  logic [CntW-1:0]     pixel_count_o;
  logic                zero_noise_o, count_overflow_o;

  image_error_statistics dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .ref_pixel_i, .test_pixel_i, .last_pixel_i,
    .out_valid_o, .out_stall_i, .mse_o, .var_ref_o, .var_noise_o,
    .pixel_count_o, .zero_noise_o, .count_overflow_o
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: configuration copy and running window sums
  logic [12:0]     fw_cfg;
  logic [11:0]     x0_cfg, y0_cfg, x1_cfg, y1_cfg;
  logic [11:0]     col_at, row_at;
  logic [CntW-1:0] win_count;
  logic [29:0]     ref_sum;
  logic [37:0]     ref_sq_sum;
  longint          diff_sum;
  logic [37:0]     diff_sq_sum;
  logic            overflowed;

  frame_stats_t frame_stats_q[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  out_stall_pct = 0;

  // Abort the run if the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("image_error_statistics_tb: done, errors");
      $finish;
    end
  end

  // Drive the result stall at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each result transfer against the oldest predicted frame
  always @(posedge clk_i) begin
    frame_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_stats_q.size() == 0) begin
        $error("unexpected result transfer, mse %0h", mse_o);
        errors++;
      end else begin
        want = frame_stats_q.pop_front();
        if (mse_o !== want.mse) begin
          $error("mse expected %0h actual %0h", want.mse, mse_o); errors++;
        end
        if (var_ref_o !== want.var_ref) begin
          $error("var_ref expected %0h actual %0h", want.var_ref, var_ref_o); errors++;
        end
        if (var_noise_o !== want.var_noise) begin
          $error("var_noise expected %0h actual %0h", want.var_noise, var_noise_o);
          errors++;
        end
        if (pixel_count_o !== want.pixel_count) begin
          $error("pixel_count expected %0d actual %0d", want.pixel_count, pixel_count_o);
          errors++;
        end
        if (zero_noise_o !== want.zero_noise) begin
          $error("zero_noise expected %0b actual %0b", want.zero_noise, zero_noise_o);
          errors++;
        end
        if (count_overflow_o !== want.count_overflow) begin
          $error("count_overflow expected %0b actual %0b", want.count_overflow,
                 count_overflow_o);
          errors++;
        end
      end
    end
  end

  // floor(num * 2^FracBits / den), saturated to 32 bits
  function automatic logic [31:0] fixed_quotient(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    q = (num << FracBits) / den;
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic clear_sums();
    col_at = '0; row_at = '0; win_count = '0;
    ref_sum = '0; ref_sq_sum = '0; diff_sum = 0; diff_sq_sum = '0;
    overflowed = 1'b0;
  endtask

  // Advance the predictor by one accepted pixel pair
  task automatic predict_pixel(logic [7:0] r, logic [7:0] t, logic last);
    logic [12:0]  w;
    longint       d;
    logic [127:0] n, dmag, num;
    frame_stats_t s;
    w = (fw_cfg == 0 || fw_cfg > MaxWidth) ? 13'(MaxWidth) : fw_cfg;
    if (col_at >= x0_cfg && col_at <= x1_cfg && row_at >= y0_cfg && row_at <= y1_cfg) begin
      if (win_count >= MaxPixels) begin
        overflowed = 1'b1;
      end else begin
        d = longint'(t) - longint'(r);
        win_count++;
        ref_sum += 30'(r);
        ref_sq_sum += 38'(r) * 38'(r);
        diff_sum += d;
        diff_sq_sum += 38'(d * d);
      end
    end
    if (13'(col_at) + 1 >= w) begin
      col_at = '0;
      row_at = row_at + 12'd1;
    end else begin
      col_at++;
    end
    if (!last) return;
    s = '{default: '0};
    n = 128'(win_count);
    if (n != 0) begin
      dmag = (diff_sum < 0) ? -diff_sum : diff_sum;
      s.mse = fixed_quotient(128'(diff_sq_sum), n);
      num = n * ref_sq_sum - ref_sum * ref_sum;
      s.var_ref = fixed_quotient(num, n * n);
      num = n * diff_sq_sum - dmag * dmag;
      s.var_noise = fixed_quotient(num, n * n);
      s.zero_noise = (num == 0);
    end
    s.pixel_count = win_count;
    s.count_overflow = overflowed;
    frame_stats_q.push_back(s);
    clear_sums();
  endtask

  // Hold one pixel transfer until the block takes it
  task automatic send_pixel(logic [7:0] r, logic [7:0] t, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ref_pixel_i = r;
    test_pixel_i = t;
    last_pixel_i = last;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixel(r, t, last);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait for every predicted frame, then let the block settle
  task automatic wait_idle();
    drop_valid();
    while (frame_stats_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CfgDataW'(val);
    case (idx)
      REG_FRAME_WIDTH: fw_cfg = 13'(val);
      REG_WIN_X0:      x0_cfg = 12'(val);
      REG_WIN_Y0:      y0_cfg = 12'(val);
      REG_WIN_X1:      x1_cfg = 12'(val);
      REG_WIN_Y1:      y1_cfg = 12'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_window(int unsigned fw, int unsigned x0, int unsigned y0,
                            int unsigned x1, int unsigned y1);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_WIN_X0, x0);
    write_reg(REG_WIN_Y0, y0);
    write_reg(REG_WIN_X1, x1);
    write_reg(REG_WIN_Y1, y1);
  endtask

  task automatic send_random_frame(int unsigned len);
    logic [7:0] r, t;
    int unsigned style;
    style = $urandom_range(3);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(255);
      case (style)
        0: t = $urandom_range(255);
        1: t = r + 8'($urandom_range(4)) - 8'd2;  // mild noise
        2: t = r + 8'd17;                          // offset of 17, wrapping modulo 256
        default: begin
          r = 8'($urandom_range(1)) * 8'd255;      // extremes only
          t = 8'($urandom_range(1)) * 8'd255;
        end
      endcase
      send_pixel(r, t, i == len - 1);
    end
  endtask

  // Extremes of the pixel range, equal and single-pixel frames, default window
  task automatic test_defaults();
    send_pixel(8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b1);
    send_pixel(8'd200, 8'd200, 1'b0);
    send_pixel(8'd10, 8'd10, 1'b1);
    send_pixel(8'd77, 8'd13, 1'b1);
    wait_idle();
  endtask

  // Window edges, inverted window and out-of-range frame widths
  task automatic test_windows();
    set_window(4, 1, 1, 2, 2);
    send_random_frame(16);
    wait_idle();
    set_window(4, 3, 0, 1, 3);  // inverted: nothing counted
    send_random_frame(8);
    wait_idle();
    set_window(0, 4095, 0, 4095, 4095);  // zero width acts as the maximum
    send_random_frame(5);
    wait_idle();
    set_window(8191, 0, 0, 0, 0);  // oversize width acts as the maximum
    send_random_frame(5);
    wait_idle();
  endtask

  // Random windows and frames under each idling pattern
  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin send_idle_pct = 61; out_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  out_stall_pct = 61; end
        default: begin send_idle_pct = 18; out_stall_pct = 18; end
      endcase
      set_window($urandom_range(1, 8), $urandom_range(3), $urandom_range(3),
                 $urandom_range(2, 7), (ph == 3) ? 4095 : $urandom_range(1, 4));
      sent = 0;
      while (sent < 90) begin
        len = $urandom_range(1, 16);
        send_random_frame(len);
        sent += len;
      end
      wait_idle();
    end
    send_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  initial begin
    fw_cfg = 13'(MaxWidth);
    x0_cfg = '0; y0_cfg = '0; x1_cfg = 12'd4095; y1_cfg = 12'd4095;
    clear_sums();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_windows();
    test_random();
    while (frame_stats_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("image_error_statistics_tb: done, clean");
    end else begin
      $display("image_error_statistics_tb: done, errors");
    end
    $finish;
  end

endmodule

### image_error_statistics.f
+incdir+src
src/ies_pkg.sv
src/ies_dp.sv
src/ies_ctrl.sv
src/image_error_statistics.sv
test/image_error_statistics_tb.sv
